/* src/ftprlp_pkg.sv */
`default_nettype none

package ftprlp_pkg;

    // Address capture limits
    localparam int ADDRESS_FIELDS = 6;
    localparam int NUMBER_WIDTH   = 16;
    localparam int PORT_WIDTH     = 25;
    localparam int CODE_WIDTH     = 10;

    localparam logic [NUMBER_WIDTH+3:0] NUM_MAX = (NUMBER_WIDTH+4)'((1 << NUMBER_WIDTH) - 1);

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Line positions of interest
    localparam logic [2:0] POS_MARK = 3'd3;
    localparam logic [2:0] POS_BARE = 3'd4;
    localparam logic [2:0] POS_TEXT = 3'd5;

    // Number count codes
    localparam logic [2:0] CNT_FULL = 3'(ADDRESS_FIELDS);
    localparam logic [2:0] CNT_OVER = 3'd7;

    typedef struct packed {
        logic [2:0]                                   line_position;
        logic                                         first_not_space;
        logic [CODE_WIDTH-1:0]                        code_acc;
        logic                                         code_good;
        logic                                         final_line;
        logic [7:0]                                   prev_byte;
        logic                                         on_first_line;
        logic [NUMBER_WIDTH-1:0]                      num_acc;
        logic                                         digits_pending;
        logic [2:0]                                   number_count;
        logic [ADDRESS_FIELDS-1:0][NUMBER_WIDTH-1:0]  addr_num;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]              text_byte;
        logic                    text_valid;
        logic                    line_done;
        logic                    reply_done;
        logic                    parse_error;
        logic [CODE_WIDTH-1:0]   reply_code;
        logic                    pasv_ok;
        logic [NUMBER_WIDTH-1:0] ip_first;
        logic [NUMBER_WIDTH-1:0] ip_second;
        logic [NUMBER_WIDTH-1:0] ip_third;
        logic [NUMBER_WIDTH-1:0] ip_fourth;
        logic [PORT_WIDTH-1:0]   pasv_port;
    } parse_result_t;

    // State of a fresh reply
    function automatic parse_state_t reset_state();
        parse_state_t s;
        s = '0;
        s.code_good     = 1'b1;
        s.on_first_line = 1'b1;
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

/* src/ftp_reply_line_parser_unit.sv */
`default_nettype none

// Channel | Direction | Ports                              | Word
// s_      | in        | s_valid s_ready s_data_byte ...    | one reply byte
// m_      | out       | m_valid m_ready m_text_byte ...    | one parse result
//
// One byte per cycle sustained while m_ready stays high; each byte passes the input stage, then the result stage.
// The rate is set by the single parser state update done once per byte.
// aresetn (synchronous, active low) empties both stages and restores the
// parser to the start of a reply.
// With m_ready low the result holds and the input stage takes one more byte.

module ftp_reply_line_parser_unit (
    input  wire  logic                                aclk,
    input  wire  logic                                aresetn,
    input  wire  logic                                s_valid,
    output logic                                      s_ready,
    input  wire  logic [7:0]                          s_data_byte,
    input  wire  logic                                s_buffer_end,
    output logic                                      m_valid,
    input  wire  logic                                m_ready,
    output logic [7:0]                                m_text_byte,
    output logic                                      m_text_valid,
    output logic                                      m_line_done,
    output logic                                      m_reply_done,
    output logic                                      m_parse_error,
    output logic [ftprlp_pkg::CODE_WIDTH-1:0]         m_reply_code,
    output logic                                      m_pasv_ok,
    output logic [ftprlp_pkg::NUMBER_WIDTH-1:0]       m_ip_first,
    output logic [ftprlp_pkg::NUMBER_WIDTH-1:0]       m_ip_second,
    output logic [ftprlp_pkg::NUMBER_WIDTH-1:0]       m_ip_third,
    output logic [ftprlp_pkg::NUMBER_WIDTH-1:0]       m_ip_fourth,
    output logic [ftprlp_pkg::PORT_WIDTH-1:0]         m_pasv_port
);
    import ftprlp_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_end_reg;
    logic          out_valid_reg;
    parse_result_t out_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_next;
    logic          advance;

    // Move a word into the result register when it is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ftprlp_step u_step (
        .cur_state  (state_reg),
        .data_byte  (in_byte_reg),
        .buffer_end (in_end_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_buffer_end;
        end
    end

    // Parser state and result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= reset_state();
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_text_byte   = out_reg.text_byte;
    assign m_text_valid  = out_reg.text_valid;
    assign m_line_done   = out_reg.line_done;
    assign m_reply_done  = out_reg.reply_done;
    assign m_parse_error = out_reg.parse_error;
    assign m_reply_code  = out_reg.reply_code;
    assign m_pasv_ok     = out_reg.pasv_ok;
    assign m_ip_first    = out_reg.ip_first;
    assign m_ip_second   = out_reg.ip_second;
    assign m_ip_third    = out_reg.ip_third;
    assign m_ip_fourth   = out_reg.ip_fourth;
    assign m_pasv_port   = out_reg.pasv_port;

    // An error word carries no other flag
    a_error_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_parse_error)
            |-> (!m_text_valid && !m_line_done && !m_reply_done && !m_pasv_ok))
        else $error("parse error word carries other flags");

    // A finished reply always ends a line
    a_reply_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reply_done) |-> m_line_done)
        else $error("reply done without line done");

    // Text is never emitted on the line-ending word
    a_text_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_text_valid) |-> !m_line_done)
        else $error("text byte on a line end");

    // Restart to a fresh reply after an error or a finished reply
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (result_next.parse_error || result_next.reply_done))
            |=> (state_reg == reset_state()))
        else $error("parser not restarted");

    // Line position saturates at the text position
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.line_position <= POS_TEXT)
        else $error("line position out of range");

endmodule

`default_nettype wire

/* src/ftprlp_step.sv */
`default_nettype none

module ftprlp_step (
    input  wire  ftprlp_pkg::parse_state_t  cur_state,
    input  wire  logic [7:0]                data_byte,
    input  wire  logic                      buffer_end,
    output ftprlp_pkg::parse_state_t        next_state,
    output ftprlp_pkg::parse_result_t       result
);
    import ftprlp_pkg::*;

    logic [2:0]              pos;
    logic [7:0]              prev;
    logic                    line_end;
    logic                    text_on;
    logic                    do_store;
    logic                    error;
    logic                    restart;
    logic [NUMBER_WIDTH+3:0] num_sum;
    logic [CODE_WIDTH+3:0]   code_sum;
    logic [PORT_WIDTH-1:0]   port_hi;

    always_comb begin
        pos  = cur_state.line_position;
        prev = cur_state.prev_byte;
        next_state = cur_state;
        result     = '0;
        error      = 1'b0;
        restart    = 1'b0;

        // Line end: CR LF with LF at position 5 or later
        line_end = (pos >= POS_TEXT) && (data_byte == CH_LF) && (prev == CH_CR);
        text_on  = (pos >= POS_TEXT) && !line_end;

        // Emit text one byte late
        if (text_on) begin
            result.text_valid = 1'b1;
            result.text_byte  = prev;
        end

        // Address scan on the first line
        num_sum = (NUMBER_WIDTH+4)'(cur_state.num_acc) * (NUMBER_WIDTH+4)'(10)
                + (NUMBER_WIDTH+4)'(4'(prev - CH_ZERO));
        if (text_on && cur_state.on_first_line && is_digit(prev)) begin
            next_state.num_acc = (num_sum > NUM_MAX) ? NUMBER_WIDTH'(NUM_MAX)
                                                     : num_sum[NUMBER_WIDTH-1:0];
            next_state.digits_pending = 1'b1;
        end
        do_store = cur_state.on_first_line
                && ((text_on && (prev == CH_COMMA))
                    || (line_end && cur_state.digits_pending));
        if (do_store) begin
            if (cur_state.number_count < CNT_FULL) begin
                next_state.addr_num[cur_state.number_count] = cur_state.num_acc;
                next_state.number_count = cur_state.number_count + 3'd1;
            end else begin
                next_state.number_count = CNT_OVER;
            end
            next_state.num_acc        = '0;
            next_state.digits_pending = 1'b0;
        end

        // Code digits and final-line mark
        code_sum = (CODE_WIDTH+4)'(cur_state.code_acc) * (CODE_WIDTH+4)'(10)
                 + (CODE_WIDTH+4)'(4'(data_byte - CH_ZERO));
        if (pos < POS_MARK) begin
            if (pos == 3'd0) begin
                next_state.first_not_space = (data_byte != CH_SPACE);
            end
            if (is_digit(data_byte)) begin
                next_state.code_acc = code_sum[CODE_WIDTH-1:0];
            end else begin
                next_state.code_good = 1'b0;
            end
        end else if (pos == POS_MARK) begin
            if (cur_state.first_not_space && (data_byte == CH_SPACE)) begin
                next_state.final_line = 1'b1;
                if (!cur_state.code_good) begin
                    error = 1'b1;
                end
            end
        end

        // Line and buffer boundaries
        if (!error) begin
            if (line_end) begin
                result.line_done = 1'b1;
                next_state.on_first_line = 1'b0;
                if (cur_state.final_line) begin
                    result.reply_done = 1'b1;
                    result.reply_code = cur_state.code_acc;
                    restart = 1'b1;
                end else begin
                    next_state.line_position   = '0;
                    next_state.first_not_space = 1'b0;
                    next_state.code_acc        = '0;
                    next_state.code_good       = 1'b1;
                    next_state.final_line      = 1'b0;
                    next_state.prev_byte       = '0;
                    restart = buffer_end;
                end
            end else if (buffer_end) begin
                if ((pos == POS_BARE) && cur_state.code_good
                        && (prev == CH_CR) && (data_byte == CH_LF)) begin
                    result.line_done  = 1'b1;
                    result.reply_done = 1'b1;
                    result.reply_code = cur_state.code_acc;
                end else begin
                    error = 1'b1;
                end
                restart = 1'b1;
            end else begin
                next_state.line_position = (pos >= POS_TEXT) ? POS_TEXT : pos + 3'd1;
                next_state.prev_byte     = data_byte;
            end
        end

        // Address outputs from the updated capture
        port_hi = PORT_WIDTH'({next_state.addr_num[4], 8'h00});
        result.pasv_ok = !next_state.on_first_line && (next_state.number_count == CNT_FULL);
        if (result.pasv_ok) begin
            result.ip_first  = next_state.addr_num[0];
            result.ip_second = next_state.addr_num[1];
            result.ip_third  = next_state.addr_num[2];
            result.ip_fourth = next_state.addr_num[3];
            result.pasv_port = port_hi + PORT_WIDTH'(next_state.addr_num[5]);
        end

        // Drop everything on error, restart after reply or buffer end
        if (error) begin
            result = '0;
            result.parse_error = 1'b1;
            next_state = reset_state();
        end else if (restart) begin
            next_state = reset_state();
        end
    end

endmodule

`default_nettype wire
